// ----- src/spr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spr_pkg: shared definitions for the sequence pooling reducer
// Register widths and indexes, pooling modes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int MAX_HIDDEN_DEF = 1024;
  localparam int MAX_SEQ_DEF    = 512;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int MODE_W     = 2;
  localparam int SEQ_LEN_W  = 10;
  localparam int HID_LEN_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [MODE_W-1:0] {
    POOL_MAX   = 2'd0,
    POOL_MEAN  = 2'd1,
    POOL_FIRST = 2'd2,
    POOL_LAST  = 2'd3
  } pool_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_MODE     = 2'd0,
    CFG_SEQ_LENGTH    = 2'd1,
    CFG_HIDDEN_LENGTH = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;       // beat accepted: capture element, read accumulator
    logic calc;       // update accumulator, advance positions
    logic div_start;  // start the mean division
    logic out_load;   // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;       // current element produces a result
    logic use_div;    // that result needs the mean division
    logic div_done;   // quotient is ready
    logic out_free;   // output register can take a new result
  } ctrl_stat_t;

endpackage
`default_nettype wire

// ----- src/spr_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spr_div: bit-serial signed by unsigned divider
// Restoring division on the magnitude, one quotient bit per cycle, with the
// sign applied at the end so the quotient truncates toward zero.
// ----------------------------------------------------------------------------
module spr_div #(
  parameter int DIVIDEND_W = 25,
  parameter int DIVISOR_W  = 10,
  parameter int QUOT_W     = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [DIVIDEND_W-1:0] dividend_i,
  input  logic        [DIVISOR_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic        [QUOT_W-1:0]     quotient_o
);
  import spr_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, done_q, neg_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d, mag;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;

  assign mag = dividend_i[DIVIDEND_W-1] ? (~dividend_i + DIVIDEND_W'(1)) : dividend_i;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
    ge     = (rem_sh >= {1'b0, divisor_i});
    rem_d  = ge ? DIVISOR_W'(rem_sh - {1'b0, divisor_i}) : rem_sh[DIVISOR_W-1:0];
    quo_d  = {quo_q[DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIVIDEND_W-1];
      rem_q <= '0;
      quo_q <= mag;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q[QUOT_W-1:0] + QUOT_W'(1)) : quo_q[QUOT_W-1:0];

endmodule
`default_nettype wire

// ----- src/spr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spr_datapath: registers, position counters, accumulator memory and result
// Holds the configuration, tracks hidden and sequence positions, performs the
// accumulator read-modify-write and keeps the output register.
// ----------------------------------------------------------------------------
module spr_datapath #(
  parameter int MAX_HIDDEN = spr_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_SEQ    = spr_pkg::MAX_SEQ_DEF,
  parameter int DATA_WIDTH = spr_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [DATA_WIDTH-1:0]           elem_value_i,
  input  spr_pkg::ctrl_cmd_t              cmd_i,
  output spr_pkg::ctrl_stat_t             stat_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [DATA_WIDTH-1:0]           pooled_value_o,
  output logic                            row_last_o
);
  import spr_pkg::*;

  localparam int H_W   = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int S_W   = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
  localparam int HL_W  = $clog2(MAX_HIDDEN + 1);
  localparam int SL_W  = $clog2(MAX_SEQ + 1);
  localparam int ACC_W = DATA_WIDTH + $clog2(MAX_SEQ);

  pool_mode_e                mode_q;
  logic [SEQ_LEN_W-1:0]      seq_len_q;
  logic [HID_LEN_W-1:0]      hid_len_q;
  logic                      cfg_hit;
  logic [H_W-1:0]            h_q, h_d;
  logic [S_W-1:0]            s_q, s_d;
  logic [SL_W-1:0]           seq_eff;
  logic [HL_W-1:0]           hid_eff;
  logic                      h_last, s_last, s_zero;

  logic signed [DATA_WIDTH-1:0] v_q;
  logic signed [ACC_W-1:0]      mem [MAX_HIDDEN];
  logic signed [ACC_W-1:0]      rd_q, v_ext, acc_new;
  logic        [DATA_WIDTH-1:0] res_q, out_data_q, quotient;
  logic                         last_q, out_last_q, out_valid_q;
  logic                         div_done;

  // Register decode: only listed indexes restart the batch row.
  always_comb begin
    unique case (cfg_idx_i)
      CFG_POOL_MODE, CFG_SEQ_LENGTH, CFG_HIDDEN_LENGTH: cfg_hit = cfg_we_i;
      default:                                          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= POOL_MAX;
      seq_len_q <= SEQ_LEN_W'(1);
      hid_len_q <= HID_LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POOL_MODE:     mode_q    <= pool_mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_SEQ_LENGTH:    seq_len_q <= cfg_data_i[SEQ_LEN_W-1:0];
        CFG_HIDDEN_LENGTH: hid_len_q <= cfg_data_i[HID_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero lengths act as one, oversized lengths as the maximum.
  always_comb begin
    if (seq_len_q == '0)            seq_eff = SL_W'(1);
    else if (int'(seq_len_q) > MAX_SEQ) seq_eff = SL_W'(MAX_SEQ);
    else                            seq_eff = SL_W'(seq_len_q);
    if (hid_len_q == '0)            hid_eff = HL_W'(1);
    else if (int'(hid_len_q) > MAX_HIDDEN) hid_eff = HL_W'(MAX_HIDDEN);
    else                            hid_eff = HL_W'(hid_len_q);
  end

  always_comb begin
    h_last = ((HL_W'(h_q) + HL_W'(1)) == hid_eff);
    s_last = ((SL_W'(s_q) + SL_W'(1)) == seq_eff);
    s_zero = (s_q == '0);
    h_d    = h_last ? '0 : h_q + H_W'(1);
    if (!h_last)     s_d = s_q;
    else if (s_last) s_d = '0;
    else             s_d = s_q + S_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
      s_q <= '0;
    end else if (cfg_hit) begin
      h_q <= '0;
      s_q <= '0;
    end else if (cmd_i.calc) begin
      h_q <= h_d;
      s_q <= s_d;
    end
  end

  // Accumulator update for the current element.
  always_comb begin
    v_ext = ACC_W'(v_q);
    if (s_zero) begin
      acc_new = v_ext;
    end else begin
      case (mode_q)
        POOL_MAX:   acc_new = (rd_q < v_ext) ? v_ext : rd_q;
        POOL_MEAN:  acc_new = rd_q + v_ext;
        POOL_FIRST: acc_new = rd_q;
        POOL_LAST:  acc_new = v_ext;
        default:    acc_new = rd_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q  <= elem_value_i;
      rd_q <= mem[h_q];
    end
    if (cmd_i.calc) begin
      mem[h_q] <= acc_new;
    end
  end

  always_comb begin
    stat_o.emit     = (mode_q == POOL_FIRST) ? s_zero : s_last;
    stat_o.use_div  = (mode_q == POOL_MEAN);
    stat_o.div_done = div_done;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  spr_div #(
    .DIVIDEND_W (ACC_W),
    .DIVISOR_W  (SL_W),
    .QUOT_W     (DATA_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_new),
    .divisor_i  (seq_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      res_q  <= acc_new[DATA_WIDTH-1:0];
      last_q <= h_last;
    end else if (div_done) begin
      res_q <= quotient;
    end
    if (cmd_i.out_load) begin
      out_data_q <= res_q;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pooled_value_o = out_data_q;
  assign row_last_o     = out_last_q;

endmodule
`default_nettype wire

// ----- src/spr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spr_ctrl: sequencing state machine
// Steps each beat through accumulator update and, for a beat that yields a
// result, optional division and the hand-off into the output register.
// ----------------------------------------------------------------------------
module spr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spr_pkg::ctrl_stat_t stat_i,
  output spr_pkg::ctrl_cmd_t  cmd_o
);
  import spr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (!stat_i.emit)        state_d = ST_IDLE;
        else if (stat_i.use_div) state_d = ST_DIV;
        else                     state_d = ST_EMIT;
      end
      ST_DIV: begin
        if (stat_i.div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.calc      = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CALC: begin
        cmd_o.calc      = 1'b1;
        cmd_o.div_start = stat_i.emit && stat_i.use_div;
      end
      ST_DIV: ;
      ST_EMIT: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/sequence_pooling_reducer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_pooling_reducer: max, mean, first or last pooling over sequence
// Streams signed fixed-point elements in batch, sequence, hidden order and
// returns one pooled value per hidden index for every batch row.
// ----------------------------------------------------------------------------
// Elements arrive one per input beat. Each hidden column is pooled over the
// seq_length positions of a batch row using one accumulator per hidden index,
// kept in an on-chip memory of MAX_HIDDEN entries; sequence row zero always
// overwrites the entry, so the memory needs no clearing after reset. In first
// mode the pooled row comes out while sequence row zero streams in, in the
// other modes while the last row streams in, with tlast marking the last
// hidden index of the row. Mean truncates toward zero. A beat that produces
// no result is accepted, then goes through the accumulator read-modify-write
// on the single memory port. A beat that produces a max, first or last
// result then moves into the output register; a mean result waits first for
// the quotient of a bit-serial divider, which yields one bit per cycle, and
// then moves into the output register as well. A result
// waits in an output register, so the next beat is accepted while the
// previous result is still pending; only a second result behind a stalled
// one waits for the output to drain. Configuration writes must be made while
// the block is idle; any write to a listed register restarts the batch row.
// ----------------------------------------------------------------------------
module sequence_pooling_reducer #(
  parameter int MAX_HIDDEN = spr_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_SEQ    = spr_pkg::MAX_SEQ_DEF,
  parameter int DATA_WIDTH = spr_pkg::DATA_WIDTH_DEF,
  parameter int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [TDATA_W-1:0]             s_axis_tdata_i,   // elem_value
  // Output stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [TDATA_W-1:0]             m_axis_tdata_o,   // pooled_value
  output logic                           m_axis_tlast_o    // row_last
);
  import spr_pkg::*;

  ctrl_cmd_t             cmd;
  ctrl_stat_t            stat;
  logic [DATA_WIDTH-1:0] pooled_value;

  spr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spr_datapath #(
    .MAX_HIDDEN (MAX_HIDDEN),
    .MAX_SEQ    (MAX_SEQ),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .elem_value_i   (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .pooled_value_o (pooled_value),
    .row_last_o     (m_axis_tlast_o)
  );

  // Upper padding bits of the output beat are zero.
  assign m_axis_tdata_o = TDATA_W'(pooled_value);

  // The input stays closed while the divider is working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !s_axis_tready_o)
    else $error("input opened during mean division");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_done |-> !s_axis_tready_o)
    else $error("quotient arrived outside the division state");

  // A result moved into the output register shows up as a valid beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid_o)
    else $error("loaded result not presented on the output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.calc, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire

// ----- tb/tb_sequence_pooling_reducer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sequence_pooling_reducer: self-checking bench for the pooling reducer
// Streams Q8.8 elements into the block under several register settings and
// compares every output beat with an in-bench model of the pooling rules or
// with a typed table value. A short directed table comes first, then random
// phases, most of them with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_sequence_pooling_reducer;
  import spr_pkg::*;

  localparam int MAX_HID = MAX_HIDDEN_DEF;
  localparam int MAX_SQ  = MAX_SEQ_DEF;
  localparam int DW      = DATA_WIDTH_DEF;
  localparam int TW      = ((DW + 7) / 8) * 8;

  // Index past the register list; the block must ignore a write to it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  // Longest time the block may still be busy after its last result, with
  // room for a mean division at the default sizes.
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 820;
  localparam int GAP_PCT       = 27;
  localparam int LIMIT_NS      = 2_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [TW-1:0]         s_axis_tdata_i = '0;   // elem_value
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [TW-1:0]         m_axis_tdata_o;        // pooled_value
  logic                  m_axis_tlast_o;        // row_last

  sequence_pooling_reducer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin : clock_gen
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Pooling model: its own copy of the registers, the column accumulators and
  // the hidden and sequence counters.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [DW-1:0] value;
    logic          last;
  } pooled_t;

  pool_mode_e           mode_reg;
  logic [SEQ_LEN_W-1:0] seq_len_reg;
  logic [HID_LEN_W-1:0] hid_len_reg;
  int                   col_acc [MAX_HID];
  int unsigned          hid_pos;
  int unsigned          seq_pos;

  // Pooled values still owed by the block, oldest first.
  pooled_t pooled_q[$];

  // A length of zero behaves as one, and a length past the maximum as the
  // maximum.
  function automatic int unsigned eff_len(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void reset_pooler();
    mode_reg    = POOL_MAX;
    seq_len_reg = 1;
    hid_len_reg = 1;
    hid_pos     = 0;
    seq_pos     = 0;
    foreach (col_acc[i]) col_acc[i] = 0;
  endfunction

  // A write to a listed register restarts the batch row; the accumulators
  // keep their contents. An unlisted index changes nothing at all.
  function automatic void write_pooler_reg(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_POOL_MODE:     mode_reg = pool_mode_e'(data[MODE_W-1:0]);
      CFG_SEQ_LENGTH:    seq_len_reg = data[SEQ_LEN_W-1:0];
      CFG_HIDDEN_LENGTH: hid_len_reg = data[HID_LEN_W-1:0];
      default:           return;
    endcase
    hid_pos = 0;
    seq_pos = 0;
  endfunction

  // Folds one element into its column and returns 1 when it yields a result.
  function automatic bit pool_element(logic [DW-1:0] elem, output pooled_t res);
    int unsigned seq;
    int unsigned hid;
    int unsigned h;
    int unsigned s;
    int          v;
    int          acc;
    bit          emit;
    seq = eff_len(seq_len_reg, MAX_SQ);
    hid = eff_len(hid_len_reg, MAX_HID);
    h   = (hid_pos >= hid) ? 0 : hid_pos;
    s   = (seq_pos >= seq) ? 0 : seq_pos;
    v   = $signed(elem);
    acc = col_acc[h];
    // Sequence row zero always overwrites the column, whatever the mode.
    if (s == 0) acc = v;
    else if (mode_reg == POOL_MAX) begin
      if (acc < v) acc = v;
    end else if (mode_reg == POOL_MEAN) acc = acc + v;
    else if (mode_reg == POOL_LAST) acc = v;
    col_acc[h] = acc;
    // First mode reports on row zero, the others on the last row; with a
    // single position both are the same row.
    if (mode_reg == POOL_FIRST) emit = (s == 0);
    else emit = (s == seq - 1);
    // Signed integer division truncates toward zero, as the mean requires.
    res.value = DW'((mode_reg == POOL_MEAN) ? acc / int'(seq) : acc);
    h++;
    if (h >= hid) begin
      h = 0;
      s++;
      if (s >= seq) s = 0;
    end
    hid_pos  = h;
    seq_pos  = s;
    res.last = (h == 0);
    return emit;
  endfunction

  // --------------------------------------------------------------------------
  // Stream drivers and the output checker.
  // --------------------------------------------------------------------------
  bit calm = 1'b0;   // set for a stretch of phases with no idling on either side
  int fail_count = 0;

  // Offers one input beat, with an optional random gap in front of it. On
  // acceptance the model is stepped; a typed expectation, where the table
  // gives one, takes the place of the predicted value. Returns at the falling
  // edge after acceptance with tvalid still high.
  task automatic send_elem(input logic [DW-1:0] elem, input bit typed,
                           input logic [DW-1:0] exp_value, input logic exp_last);
    pooled_t res;
    bit      emit;
    if (!calm && $urandom_range(99) < GAP_PCT) begin
      s_axis_tvalid_i = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < GAP_PCT);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = TW'(elem);
    do @(posedge clk_i); while (!s_axis_tready_o);
    emit = pool_element(elem, res);
    if (typed) begin
      res.value = exp_value;
      res.last  = exp_last;
      pooled_q.push_back(res);
    end else if (emit) begin
      pooled_q.push_back(res);
    end
    @(negedge clk_i);
  endtask

  // Registers may only change while the block is idle: every owed result has
  // drained and any beat that yields nothing has had time to finish.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    s_axis_tvalid_i = 1'b0;
    while (pooled_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    write_pooler_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = calm || ($urandom_range(99) >= GAP_PCT);
    end
  end

  always @(posedge clk_i) begin
    pooled_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pooled_q.size() == 0) begin
        $error("unexpected output beat: pooled_value %h, row_last %b",
               m_axis_tdata_o[DW-1:0], m_axis_tlast_o);
        fail_count++;
      end else begin
        want = pooled_q.pop_front();
        if (m_axis_tdata_o[DW-1:0] !== want.value) begin
          $error("pooled_value: expected %h, actual %h", want.value,
                 m_axis_tdata_o[DW-1:0]);
          fail_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("row_last: expected %b, actual %b", want.last, m_axis_tlast_o);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table. A row is either a register write or an element; an
  // element row may carry a typed expectation, otherwise the model decides.
  // --------------------------------------------------------------------------
  typedef enum bit {ROW_ELEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [DW-1:0]         elem;
    bit                    typed;
    logic [DW-1:0]         exp_value;
    logic                  exp_last;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    directed.push_back('{ROW_CFG, idx, data, '0, 1'b0, '0, 1'b0});
  endfunction

  function automatic void elem_row(logic [DW-1:0] elem);
    directed.push_back('{ROW_ELEM, '0, '0, elem, 1'b0, '0, 1'b0});
  endfunction

  function automatic void check_row(logic [DW-1:0] elem, logic [DW-1:0] exp_value,
                                    logic exp_last);
    directed.push_back('{ROW_ELEM, '0, '0, elem, 1'b1, exp_value, exp_last});
  endfunction

  function automatic void build_directed();
    // Reset values: max mode, one position, one column, so every element
    // comes straight back as the last of its row.
    check_row(16'h7FFF, 16'h7FFF, 1'b1);
    check_row(16'h8000, 16'h8000, 1'b1);
    // A zero sequence length behaves as one; two columns per row.
    cfg_row(CFG_SEQ_LENGTH, 11'd0);
    cfg_row(CFG_HIDDEN_LENGTH, 11'd2);
    cfg_row(CFG_POOL_MODE, CFG_DATA_W'(POOL_MEAN));
    check_row(16'hFFFF, 16'hFFFF, 1'b0);
    check_row(16'h0001, 16'h0001, 1'b1);
    // Max over three positions, with the most negative value first.
    cfg_row(CFG_POOL_MODE, CFG_DATA_W'(POOL_MAX));
    cfg_row(CFG_SEQ_LENGTH, 11'd3);
    cfg_row(CFG_HIDDEN_LENGTH, 11'd1);
    elem_row(16'h8000);
    elem_row(16'h7FFF);
    check_row(16'h8000, 16'h7FFF, 1'b1);
    // Mean of the most negative value, then a small negative sum that must
    // truncate toward zero rather than round down.
    cfg_row(CFG_POOL_MODE, CFG_DATA_W'(POOL_MEAN));
    elem_row(16'h8000);
    elem_row(16'h8000);
    check_row(16'h8000, 16'h8000, 1'b1);
    elem_row(16'hFFFF);
    elem_row(16'hFFFF);
    check_row(16'h0000, 16'h0000, 1'b1);
    // First mode reports on row zero and stays silent afterwards.
    cfg_row(CFG_POOL_MODE, CFG_DATA_W'(POOL_FIRST));
    check_row(16'h0005, 16'h0005, 1'b1);
    elem_row(16'h0006);
    elem_row(16'h0007);
    // Last mode; a write to an unlisted index mid-row must not restart it.
    cfg_row(CFG_POOL_MODE, CFG_DATA_W'(POOL_LAST));
    elem_row(16'h0005);
    cfg_row(CFG_IDX_UNUSED, 11'h7FF);
    elem_row(16'h0006);
    check_row(16'h0007, 16'h0007, 1'b1);
    // A listed write mid-row does restart it.
    elem_row(16'h0001);
    cfg_row(CFG_POOL_MODE, CFG_DATA_W'(POOL_LAST));
    elem_row(16'h0002);
    elem_row(16'h0003);
    check_row(16'h0004, 16'h0004, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned      seq_e;
    int unsigned      hid_e;
    int               n;
    int               phase;
    int               rand_items;
    logic [DW-1:0]    elem;
    reset_pooler();
    build_directed();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) write_cfg(directed[i].idx, directed[i].data);
      else send_elem(directed[i].elem, directed[i].typed, directed[i].exp_value,
                     directed[i].exp_last);
    end

    // Random phases. The first runs the longest mean once, with a sequence
    // length past the maximum over a single column. The rest use small
    // sizes, mostly whole batch rows, with a partial row now and then.
    phase      = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      calm = (phase >= 2 && phase < 5);
      if (phase == 0) begin
        write_cfg(CFG_POOL_MODE, {9'($urandom), 2'(POOL_MEAN)});
        write_cfg(CFG_SEQ_LENGTH, {1'($urandom), 10'($urandom_range(1023, MAX_SQ + 1))});
        write_cfg(CFG_HIDDEN_LENGTH, 11'd1);
      end else begin
        if ($urandom_range(9) == 0) write_cfg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom));
        if ($urandom_range(3) != 0) write_cfg(CFG_POOL_MODE, CFG_DATA_W'($urandom));
        write_cfg(CFG_SEQ_LENGTH, {1'($urandom), 10'($urandom_range(6))});
        write_cfg(CFG_HIDDEN_LENGTH, CFG_DATA_W'($urandom_range(12)));
      end

      seq_e = eff_len(seq_len_reg, MAX_SQ);
      hid_e = eff_len(hid_len_reg, MAX_HID);
      if (phase == 0) begin
        n = seq_e * hid_e + $urandom_range(1, 4);
      end else begin
        n = seq_e * hid_e * $urandom_range(1, 3);
        if ($urandom_range(3) == 0) n += $urandom_range(1, seq_e * hid_e);
      end
      rand_items += n;

      repeat (n) begin
        // Full-scale values now and then, so the max and mean see extremes.
        case ($urandom_range(7))
          0:       elem = 16'h7FFF;
          1:       elem = 16'h8000;
          default: elem = DW'($urandom);
        endcase
        send_elem(elem, 1'b0, '0, 1'b0);
      end
      phase++;
    end

    calm = 1'b0;
    s_axis_tvalid_i = 1'b0;
    while (pooled_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb_sequence_pooling_reducer: PASS");
    end else begin
      $display("tb_sequence_pooling_reducer: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("tb_sequence_pooling_reducer: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/spr_pkg.sv
src/spr_div.sv
src/spr_datapath.sv
src/spr_ctrl.sv
src/sequence_pooling_reducer.sv
tb/tb_sequence_pooling_reducer.sv
